// ===== design/fpmds_pkg.sv =====
// Shared widths, operation codes and types of the Q16.16 multiply, divide and square root unit.
`default_nettype none

package fpmds_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int DIVD_W    = DATA_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIVD_W);
    localparam int SQ_W      = DATA_W + 2;
    localparam int OP_W      = 2;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [DIVD_W-1:0] divd_t;
    typedef logic [OP_W-1:0]   op_code_t;

    localparam op_code_t OP_MUL  = 2'd0;
    localparam op_code_t OP_DIV  = 2'd1;
    localparam op_code_t OP_SQRT = 2'd2;

    // Status of the iterative divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== design/fpmds_req_if.sv =====
// Request channel: operation selector and two Q16.16 operands.
`default_nettype none

interface fpmds_req_if;
    logic                                 valid;
    logic                                 ready;
    fpmds_pkg::op_code_t                  req_type;
    logic signed [fpmds_pkg::DATA_W-1:0]  operand_a;
    logic signed [fpmds_pkg::DATA_W-1:0]  operand_b;

    modport source (output valid, output req_type, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input req_type, input operand_a, input operand_b,
                    output ready);
endinterface

`default_nettype wire

// ===== design/fpmds_rsp_if.sv =====
// Response channel: Q16.16 result word and the divide-by-zero flag.
`default_nettype none

interface fpmds_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fpmds_pkg::DATA_W-1:0]  result_value;
    logic                                 divide_by_zero;

    modport source (output valid, output result_value, output divide_by_zero, input ready);
    modport sink   (input valid, input result_value, input divide_by_zero, output ready);
endinterface

`default_nettype wire

// ===== design/fixed_point_mul_div_sqrt.sv =====
// A multiply passes S_MUL and S_MUL_END, a divide S_DIV_LOAD and then S_DIV_RUN until the divider
// is done, a square root S_SQ_MUL and S_SQ_CMP per probe; other codes and early exits go to S_FIN.
// One word is in work at a time: req.ready is high only while the sequencer is idle, and the
// output register lets a new word be accepted while the last result still waits.
// Divide steps through the one-bit-per-cycle divider; square root uses the shared multiplier.
// rst_n clears the sequencer, the divider control and the output valid asynchronously.
`default_nettype none

module fixed_point_mul_div_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    fpmds_req_if.sink   req,
    fpmds_rsp_if.source rsp
);

    // Sequencer states. Each square root probe passes S_SQ_MUL for the multiply and S_SQ_CMP
    // for the compare, which also forms the next probe from both possible outcomes.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MUL_END,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_SQ_MUL,
        S_SQ_CMP,
        S_FIN
    } state_t;

    localparam int DW = fpmds_pkg::DATA_W;
    localparam int SW = fpmds_pkg::SQ_W;
    localparam logic signed [SW-1:0] SQ_ONE = SW'(1);

    state_t state_reg, state_next;

    // Operand registers loaded when a word is accepted.
    logic signed [DW-1:0]  op_a_reg, op_a_next;
    fpmds_pkg::word_t      mag_a_reg, mag_a_next;
    fpmds_pkg::word_t      mag_b_reg, mag_b_next;
    logic                  neg_reg, neg_next;

    // Bisection bounds. They are two bits wider than a word: the lower bound can step
    // one past the largest positive word and the upper bound can drop to minus one.
    logic signed [SW-1:0]  hi_reg, hi_next;
    logic signed [SW-1:0]  lo_reg, lo_next;
    fpmds_pkg::word_t      mid_reg, mid_next;

    // Finished result waiting for the output register.
    fpmds_pkg::word_t      res_reg, res_next;
    logic                  flag_reg, flag_next;

    logic                  out_valid_reg, out_valid_next;
    fpmds_pkg::word_t      out_value_reg, out_value_next;
    logic                  out_flag_reg, out_flag_next;

    logic                  accept;
    logic signed [DW-1:0]  in_a;
    logic signed [DW-1:0]  in_b;

    fpmds_pkg::word_t      mul_a;
    fpmds_pkg::word_t      mul_b;
    fpmds_pkg::prod_t      prod;
    fpmds_pkg::word_t      prod_mid;

    logic                  div_start;
    fpmds_pkg::divd_t      div_quo;
    fpmds_pkg::div_stat_t  div_stat;

    logic signed [DW-1:0]  sq;
    logic signed [SW-1:0]  mid_ext;
    logic signed [SW-1:0]  lo_up;
    logic signed [SW-1:0]  hi_dn;
    logic signed [SW-1:0]  mid_lt;
    logic signed [SW-1:0]  mid_gt;
    logic                  cont_lt;
    logic                  cont_gt;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign in_a      = req.operand_a;
    assign in_b      = req.operand_b;

    // The multiplier squares the probe during square root and otherwise sees the magnitudes.
    assign mul_a = (state_reg == S_SQ_MUL) ? mid_reg : mag_a_reg;
    assign mul_b = (state_reg == S_SQ_MUL) ? mid_reg : mag_b_reg;

    fpmds_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign div_start = (state_reg == S_DIV_LOAD);

    fpmds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({mag_a_reg, {fpmds_pkg::FRAC_W{1'b0}}}),
        .divisor  (mag_b_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // Q16.16 scaling keeps product bits 47..16.
    assign prod_mid = prod[fpmds_pkg::FRAC_W +: DW];
    assign sq       = prod_mid;

    // Both successors of the current probe are formed in parallel; the compare picks one.
    assign mid_ext = {2'b00, mid_reg};
    assign lo_up   = mid_ext + SQ_ONE;
    assign hi_dn   = mid_ext - SQ_ONE;
    assign mid_lt  = (hi_reg + lo_up) >>> 1;
    assign mid_gt  = (hi_dn + lo_reg) >>> 1;
    assign cont_lt = (hi_reg > lo_up);
    assign cont_gt = (hi_dn > lo_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_a_next      = op_a_reg;
        mag_a_next     = mag_a_reg;
        mag_b_next     = mag_b_reg;
        neg_next       = neg_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        res_next       = res_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_flag_next  = out_flag_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // The magnitude of the most negative word wraps to 2^31, which is
                    // exactly its unsigned pattern.
                    op_a_next  = in_a;
                    mag_a_next = in_a[DW-1] ? -in_a : in_a;
                    mag_b_next = in_b[DW-1] ? -in_b : in_b;
                    neg_next   = in_a[DW-1] ^ in_b[DW-1];
                    hi_next    = {{2{in_a[DW-1]}}, in_a};
                    lo_next    = '0;
                    mid_next   = in_a >>> 1;
                    flag_next  = 1'b0;
                    res_next   = '0;
                    case (req.req_type)
                        fpmds_pkg::OP_MUL:
                        begin
                            state_next = S_MUL;
                        end
                        fpmds_pkg::OP_DIV:
                        begin
                            if (in_b == '0)
                            begin
                                flag_next  = 1'b1;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_DIV_LOAD;
                            end
                        end
                        fpmds_pkg::OP_SQRT:
                        begin
                            // A radicand that is zero or negative never enters the search,
                            // so the answer is the radicand halved.
                            if (in_a > 0)
                            begin
                                state_next = S_SQ_MUL;
                            end
                            else
                            begin
                                res_next   = in_a >>> 1;
                                state_next = S_FIN;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                state_next = S_MUL_END;
            end
            S_MUL_END:
            begin
                res_next   = neg_reg ? -prod_mid : prod_mid;
                state_next = S_FIN;
            end
            S_DIV_LOAD:
            begin
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                if (div_stat.done)
                begin
                    res_next   = neg_reg ? -div_quo[DW-1:0] : div_quo[DW-1:0];
                    state_next = S_FIN;
                end
            end
            S_SQ_MUL:
            begin
                state_next = S_SQ_CMP;
            end
            S_SQ_CMP:
            begin
                if (sq == op_a_reg)
                begin
                    res_next   = mid_reg;
                    state_next = S_FIN;
                end
                else if (sq < op_a_reg)
                begin
                    lo_next = lo_up;
                    if (cont_lt)
                    begin
                        mid_next   = mid_lt[DW-1:0];
                        state_next = S_SQ_MUL;
                    end
                    else
                    begin
                        res_next   = mid_lt[DW-1:0];
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    hi_next = hi_dn;
                    if (cont_gt)
                    begin
                        mid_next   = mid_gt[DW-1:0];
                        state_next = S_SQ_MUL;
                    end
                    else
                    begin
                        res_next   = mid_gt[DW-1:0];
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                // Hand the result to the output register once it is empty or being taken.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    out_flag_next  = flag_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_flag_reg  <= out_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_a_reg  <= op_a_next;
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        neg_reg   <= neg_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        res_reg   <= res_next;
        flag_reg  <= flag_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.result_value   = out_value_reg;
    assign rsp.divide_by_zero = out_flag_reg;

`ifndef NO_ASSERTIONS
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.divide_by_zero |-> rsp.result_value == '0)
        else $error("divide_by_zero word carries a nonzero result");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("sequencer still ready after accepting a word");

    a_div_scope: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == S_DIV_RUN)
        else $error("divider running outside a divide");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && (!rsp.valid || rsp.ready) |=> rsp.valid && state_reg == S_IDLE)
        else $error("finished result not moved to the output register");
`endif

endmodule

`default_nettype wire

// ===== design/fpmds_mul.sv =====
// Shared 32 x 32 unsigned multiplier with a registered 64-bit product.
`default_nettype none

module fpmds_mul (
    input  logic                 clk,
    input  fpmds_pkg::word_t     op_a,
    input  fpmds_pkg::word_t     op_b,
    output fpmds_pkg::prod_t     prod
);

    fpmds_pkg::prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= fpmds_pkg::PROD_W'(op_a) * fpmds_pkg::PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== design/fpmds_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none

module fpmds_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  fpmds_pkg::divd_t        dividend,
    input  fpmds_pkg::word_t        divisor,
    output fpmds_pkg::divd_t        quotient,
    output fpmds_pkg::div_stat_t    stat
);

    localparam logic [fpmds_pkg::DIV_CNT_W-1:0] LAST_STEP =
        fpmds_pkg::DIV_CNT_W'(fpmds_pkg::DIVD_W - 1);

    logic [fpmds_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;
    fpmds_pkg::word_t                rem_reg;
    fpmds_pkg::divd_t                quo_reg;
    fpmds_pkg::word_t                dsr_reg;

    logic [fpmds_pkg::DATA_W:0]      trial;
    logic [fpmds_pkg::DATA_W:0]      diff;
    logic                            fits;

    // The dividend shifts out of the top of quo_reg while quotient bits shift in below.
    assign trial = {rem_reg, quo_reg[fpmds_pkg::DIVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= LAST_STEP;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[fpmds_pkg::DATA_W-1:0] : trial[fpmds_pkg::DATA_W-1:0];
            quo_reg <= {quo_reg[fpmds_pkg::DIVD_W-2:0], fits};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire
